// ===== rtl/core/assert_macros.svh =====
// concurrent assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

// ===== rtl/core/s256_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package s256_pkg;

    typedef logic [8:0] t_m257;

    localparam int BLOCK_BYTES = 64;
    localparam int NTT_OUTS    = 128;

    localparam logic [7:0] NTT_ALPHA = 8'd139;
    localparam logic [7:0] NTT_BETA  = 8'd98;
    localparam logic [7:0] NTT_FIN   = 8'd58;
    localparam logic [7:0] MUL_LO    = 8'd185;
    localparam logic [7:0] MUL_HI    = 8'd233;

    localparam logic [4:0] WORD_ORDER [32] = '{
        5'd4,  5'd6,  5'd0,  5'd2,  5'd7,  5'd5,  5'd3,  5'd1,
        5'd15, 5'd11, 5'd12, 5'd8,  5'd9,  5'd13, 5'd10, 5'd14,
        5'd17, 5'd18, 5'd23, 5'd20, 5'd22, 5'd21, 5'd16, 5'd19,
        5'd30, 5'd24, 5'd25, 5'd31, 5'd27, 5'd29, 5'd28, 5'd26
    };

    localparam logic [4:0] ROT [4][4] = '{
        '{5'd3,  5'd23, 5'd17, 5'd27},
        '{5'd28, 5'd19, 5'd22, 5'd7},
        '{5'd29, 5'd9,  5'd15, 5'd5},
        '{5'd4,  5'd13, 5'd10, 5'd25}
    };

    localparam logic [4:0] FF_ROT [4] = '{5'd4, 5'd13, 5'd10, 5'd25};

    // initial value text, zero padded, little-endian words
    function automatic logic [31:0] iv_word(input logic [3:0] idx);
        logic [31:0] w;
        case (idx)
            4'd0:    w = 32'h444D4953;
            4'd1:    w = 32'h3635322D;
            4'd2:    w = 32'h2E317620;
            4'd3:    w = 32'h00000031;
            default: w = 32'h0;
        endcase
        return w;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
        return (x << n) | (x >> (6'd32 - {1'b0, n}));
    endfunction

    function automatic logic [15:0] lo16mul(input logic [8:0] y, input logic [7:0] m);
        logic signed [17:0] p;
        p = $signed(y) * $signed({1'b0, m});
        return p[15:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/s256_mmac.sv =====
`timescale 1ns / 1ps
`default_nettype none
module s256_mmac import s256_pkg::*; (
    input  wire t_m257 i_x,
    input  wire t_m257 i_y,
    input  wire t_m257 i_z,
    output t_m257      o_res
);
    logic [17:0] w_p;
    logic [17:0] w_r;
    logic [10:0] w_d;

    // 256 == -1 mod 257, so value = lo - hi
    always_comb begin
        w_p = {9'd0, i_x} * {9'd0, i_y};
        w_r = w_p + {9'd0, i_z};
        w_d = {3'd0, w_r[7:0]} - {1'b0, w_r[17:8]};
        if (w_d[10]) begin
            w_d = w_d + 11'd257;
        end
        o_res = w_d[8:0];
    end
endmodule
`default_nettype wire

// ===== rtl/core/simd256_hash.sv =====
// one message byte per request while collecting a block, with o_ready low after
// each accepted byte until the dispatch state returns to idle; each 64-byte block
// compresses through the single mod-257 multiply-add unit (128 outputs) plus 36 steps
// the final byte costs up to two compressions, then eight digest words
// reset (i_rst_n low, synchronous) clears state and recompresses the initial
// value with o_ready low; the same follows every digest
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module simd256_hash import s256_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [7:0]  i_data_byte,
    input  wire  [3:0]  i_byte_bits,
    input  wire         i_last_byte,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_digest_index,
    output logic        o_digest_last
);
    typedef enum logic [2:0] {S_DISP, S_IDLE, S_XOR, S_NTT, S_STEP, S_OUT} t_state;
    typedef enum logic [1:0] {SRC_DATA, SRC_LEN, SRC_IV} t_src;

    t_state      r_state;
    t_src        r_src;
    logic        r_fin;
    logic        r_pend_full, r_pend_tail, r_pend_len, r_pend_out, r_pend_iv;
    logic [5:0]  r_pos;
    logic [6:0]  r_fill;
    logic [63:0] r_cnt;
    logic [31:0] r_st [16];
    logic [31:0] r_saved [16];
    logic [31:0] r_buf [16];
    logic [31:0] r_anew [4];
    logic [3:0]  r_xi;
    logic [6:0]  r_oi;
    logic [5:0]  r_bj;
    logic [2:0]  r_nsub;
    t_m257       r_h, r_apow, r_bpow, r_fpow;
    logic [5:0]  r_s;
    logic [1:0]  r_j;
    logic [1:0]  r_ssub;
    logic [1:0]  r_mod3;
    logic [8:0]  r_y0;
    logic [31:0] r_w;
    logic [2:0]  r_oidx;
    logic [8:0]  r_ymem [NTT_OUTS];
    logic [8:0]  r_ydata;

    // block source
    logic [3:0]  w_addr;
    logic [31:0] w_word;
    logic [7:0]  w_byte;

    always_comb begin
        w_addr = (r_state == S_XOR) ? r_xi : r_bj[5:2];
        case (r_src)
            SRC_DATA: begin
                w_word = r_buf[w_addr];
                for (int b = 0; b < 4; b++) begin
                    if (!({1'b0, w_addr, 2'(b)} < r_fill)) begin
                        w_word[8*b +: 8] = 8'd0;
                    end
                end
            end
            SRC_LEN: begin
                case (w_addr)
                    4'd0:    w_word = r_cnt[31:0];
                    4'd1:    w_word = r_cnt[63:32];
                    default: w_word = 32'd0;
                endcase
            end
            SRC_IV:  w_word = iv_word(w_addr);
            default: w_word = 32'd0;
        endcase
        w_byte = w_word[8*r_bj[1:0] +: 8];
    end

    // shared mod-257 multiply-add
    t_m257 w_mx, w_my, w_mz, w_mres;

    always_comb begin
        case (r_nsub)
            3'd0: begin w_mx = r_h;    w_my = r_apow;         w_mz = {1'b0, w_byte}; end
            3'd1: begin w_mx = r_h;    w_my = 9'd1;           w_mz = r_bpow; end
            3'd2: begin w_mx = r_h;    w_my = 9'd1;           w_mz = r_fin ? r_fpow : 9'd0; end
            3'd3: begin w_mx = r_apow; w_my = {1'b0, NTT_ALPHA}; w_mz = 9'd0; end
            3'd4: begin w_mx = r_bpow; w_my = {1'b0, NTT_BETA};  w_mz = 9'd0; end
            3'd5: begin w_mx = r_fpow; w_my = {1'b0, NTT_FIN};   w_mz = 9'd0; end
            default: begin w_mx = 9'd0; w_my = 9'd0; w_mz = 9'd0; end
        endcase
    end

    s256_mmac u_mmac (
        .i_x   (w_mx),
        .i_y   (w_my),
        .i_z   (w_mz),
        .o_res (w_mres)
    );

    // centered transform value
    logic [8:0] w_yval;
    assign w_yval = (w_mres > 9'd128) ? (w_mres + 9'd255) : w_mres;

    // step datapath
    logic        w_ff, w_maj;
    logic [4:0]  w_z, w_rr, w_sft;
    logic [6:0]  w_i0, w_i1, w_raddr;
    logic [7:0]  w_m;
    logic [1:0]  w_pj;
    logic [31:0] w_a, w_b, w_c, w_d, w_ap, w_t, w_tp, w_f, w_v;

    always_comb begin
        w_ff = r_s[5];
        w_z  = WORD_ORDER[r_s[4:0]];
        if (w_z < 5'd16) begin
            w_i0 = {w_z[3:0], r_j, 1'b0};
            w_i1 = {w_z[3:0], r_j, 1'b1};
            w_m  = MUL_LO;
        end else if (w_z < 5'd24) begin
            w_i0 = {1'b0, w_z[2:0], r_j, 1'b0};
            w_i1 = {1'b1, w_z[2:0], r_j, 1'b0};
            w_m  = MUL_HI;
        end else begin
            w_i0 = {1'b0, w_z[2:0], r_j, 1'b1};
            w_i1 = {1'b1, w_z[2:0], r_j, 1'b1};
            w_m  = MUL_HI;
        end
        w_raddr = (r_ssub == 2'd0) ? w_i0 : w_i1;
        w_rr    = w_ff ? FF_ROT[r_s[1:0]] : ROT[r_s[4:3]][r_s[1:0]];
        w_sft   = w_ff ? FF_ROT[r_s[1:0] + 2'd1] : ROT[r_s[4:3]][r_s[1:0] + 2'd1];
        w_maj   = !w_ff && r_s[2];
        // lane permutation is an xor with 1, 2, 3 in turn
        w_pj = r_j ^ (r_mod3 + 2'd1);
        w_a  = r_st[{2'd0, r_j}];
        w_b  = r_st[{2'd1, r_j}];
        w_c  = r_st[{2'd2, r_j}];
        w_d  = r_st[{2'd3, r_j}];
        w_ap = r_st[{2'd0, w_pj}];
        w_t  = rotl32(w_a, w_rr);
        w_tp = rotl32(w_ap, w_rr);
        w_f  = w_maj ? ((w_a & w_b) | (w_a & w_c) | (w_b & w_c))
                     : ((w_a & w_b) | (~w_a & w_c));
        w_v  = rotl32(w_d + r_w + w_f, w_sft) + w_tp;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_NTT && r_nsub == 3'd2) begin
            r_ymem[r_oi] <= w_yval;
        end
        r_ydata <= r_ymem[w_raddr];
    end

    // request decode
    logic       n_b8, n_full;
    logic [6:0] n_fill;
    logic [7:0] n_byte;

    always_comb begin
        n_b8   = !i_last_byte || (i_byte_bits >= 4'd8);
        n_full = n_b8 && (r_pos == 6'd63);
        n_byte = n_b8 ? i_data_byte : (i_data_byte & ~(8'hff >> i_byte_bits[2:0]));
        if (n_full) begin
            n_fill = 7'(BLOCK_BYTES);
        end else if (n_b8) begin
            n_fill = {1'b0, r_pos} + 7'd1;
        end else begin
            n_fill = {1'b0, r_pos} + {6'd0, (i_byte_bits != 4'd0)};
        end
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = (r_state == S_OUT);
    assign o_digest_word  = r_st[{1'b0, r_oidx}];
    assign o_digest_index = r_oidx;
    assign o_digest_last  = (r_oidx == 3'd7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_DISP;
            r_src       <= SRC_IV;
            r_fin       <= 1'b0;
            r_pend_full <= 1'b0;
            r_pend_tail <= 1'b0;
            r_pend_len  <= 1'b0;
            r_pend_out  <= 1'b0;
            r_pend_iv   <= 1'b1;
            r_pos       <= 6'd0;
            r_fill      <= 7'd0;
            r_cnt       <= 64'd0;
            r_oidx      <= 3'd0;
            r_nsub      <= 3'd0;
            r_ssub      <= 2'd0;
            for (int k = 0; k < 16; k++) begin
                r_st[k] <= 32'd0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (n_b8 || i_byte_bits != 4'd0) begin
                            r_buf[r_pos[5:2]][8*r_pos[1:0] +: 8] <= n_byte;
                        end
                        r_cnt       <= r_cnt + (n_b8 ? 64'd8 : {60'd0, i_byte_bits});
                        r_pos       <= n_full ? 6'd0 : (n_b8 ? r_pos + 6'd1 : r_pos);
                        r_fill      <= n_fill;
                        r_pend_full <= n_full;
                        r_pend_tail <= i_last_byte && !n_full && (n_fill != 7'd0);
                        r_pend_len  <= i_last_byte;
                        r_pend_out  <= i_last_byte;
                        r_state     <= S_DISP;
                    end
                end
                S_DISP: begin
                    r_xi <= 4'd0;
                    for (int k = 0; k < 16; k++) begin
                        r_saved[k] <= r_st[k];
                    end
                    if (r_pend_full || r_pend_tail) begin
                        r_pend_full <= 1'b0;
                        r_pend_tail <= 1'b0;
                        r_src       <= SRC_DATA;
                        r_fin       <= 1'b0;
                        r_state     <= S_XOR;
                    end else if (r_pend_len) begin
                        r_pend_len <= 1'b0;
                        r_src      <= SRC_LEN;
                        r_fin      <= 1'b1;
                        r_state    <= S_XOR;
                    end else if (r_pend_out) begin
                        r_pend_out <= 1'b0;
                        r_oidx     <= 3'd0;
                        r_state    <= S_OUT;
                    end else if (r_pend_iv) begin
                        r_pend_iv <= 1'b0;
                        r_src     <= SRC_IV;
                        r_fin     <= 1'b0;
                        r_state   <= S_XOR;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_XOR: begin
                    r_st[r_xi] <= r_st[r_xi] ^ w_word;
                    r_xi       <= r_xi + 4'd1;
                    if (r_xi == 4'd15) begin
                        r_oi    <= 7'd0;
                        r_bj    <= 6'd63;
                        r_nsub  <= 3'd0;
                        r_h     <= 9'd0;
                        r_apow  <= 9'd1;
                        r_bpow  <= 9'd1;
                        r_fpow  <= 9'd1;
                        r_state <= S_NTT;
                    end
                end
                S_NTT: begin
                    case (r_nsub)
                        // horner over the block bytes, last byte first
                        3'd0: begin
                            r_h <= w_mres;
                            if (r_bj == 6'd0) begin
                                r_nsub <= 3'd1;
                            end else begin
                                r_bj <= r_bj - 6'd1;
                            end
                        end
                        3'd1: begin
                            r_h    <= w_mres;
                            r_nsub <= 3'd2;
                        end
                        3'd2: begin
                            r_h    <= 9'd0;
                            r_nsub <= 3'd3;
                        end
                        3'd3: begin
                            r_apow <= w_mres;
                            r_nsub <= 3'd4;
                        end
                        3'd4: begin
                            r_bpow <= w_mres;
                            r_nsub <= 3'd5;
                        end
                        3'd5: begin
                            r_fpow <= w_mres;
                            r_nsub <= 3'd0;
                            r_bj   <= 6'd63;
                            r_oi   <= r_oi + 7'd1;
                            if (r_oi == 7'(NTT_OUTS - 1)) begin
                                r_s     <= 6'd0;
                                r_j     <= 2'd0;
                                r_ssub  <= 2'd0;
                                r_mod3  <= 2'd0;
                                r_state <= S_STEP;
                            end
                        end
                        default: r_nsub <= 3'd0;
                    endcase
                end
                S_STEP: begin
                    r_ssub <= r_ssub + 2'd1;
                    case (r_ssub)
                        2'd1: r_y0 <= r_ydata;
                        2'd2: begin
                            if (w_ff) begin
                                r_w <= r_saved[{r_s[1:0], r_j}];
                            end else begin
                                r_w <= {lo16mul(r_ydata, w_m), lo16mul(r_y0, w_m)};
                            end
                        end
                        2'd3: begin
                            r_st[{2'd3, r_j}] <= w_c;
                            r_st[{2'd2, r_j}] <= w_b;
                            r_st[{2'd1, r_j}] <= w_t;
                            r_anew[r_j]       <= w_v;
                            r_j               <= r_j + 2'd1;
                            if (r_j == 2'd3) begin
                                // a lanes change together once all lanes have read them
                                r_st[0] <= r_anew[0];
                                r_st[1] <= r_anew[1];
                                r_st[2] <= r_anew[2];
                                r_st[3] <= w_v;
                                r_s     <= r_s + 6'd1;
                                r_mod3  <= (r_mod3 == 2'd2) ? 2'd0 : r_mod3 + 2'd1;
                                if (r_s == 6'd35) begin
                                    r_state <= S_DISP;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            for (int k = 0; k < 16; k++) begin
                                r_st[k] <= 32'd0;
                            end
                            r_cnt     <= 64'd0;
                            r_pos     <= 6'd0;
                            r_pend_iv <= 1'b1;
                            r_state   <= S_DISP;
                        end
                    end
                end
                default: r_state <= S_DISP;
            endcase
        end
    end

    `ASSERT_NEVER(a_no_both, i_clk, i_rst_n, o_ready && o_valid, "ready while digest shown")
    `ASSERT_NEVER(a_nsub_range, i_clk, i_rst_n, r_state == S_NTT && r_nsub > 3'd5, "bad ntt phase")
    `ASSERT_NEVER(a_mod_range, i_clk, i_rst_n, r_state == S_NTT && w_mres > 9'd256,
                  "mod 257 result out of range")
    `ASSERT_CLK(a_restart, i_clk, i_rst_n, o_valid && i_ready && o_digest_last |=> !o_ready && !o_valid, "no restart after digest")

endmodule
`default_nettype wire
